### hw/rtl/grid_dda_column_raycaster_defines.svh
// Assertion macros shared by the raycaster RTL.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef GRID_DDA_COLUMN_RAYCASTER_DEFINES_SVH
`define GRID_DDA_COLUMN_RAYCASTER_DEFINES_SVH
`ifndef SYNTHESIS
`define GDDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("raycaster check failed");
`define GDDA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("raycaster check failed");
`else
`define GDDA_ASSERT(lbl, prop)
`define GDDA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/gdda_pkg.sv
// Shared types, constants and the wall color function of the grid raycaster.
// No dependencies; used by gdda_div and grid_dda_column_raycaster.
package gdda_pkg;

  localparam int POS_W     = 21;
  localparam int DIR_W     = 18;
  localparam int COL_W     = 11;
  localparam int CELL_W    = 5;
  localparam int CODE_W    = 3;
  localparam int ROW_W     = 11;
  localparam int COLOR_W   = 8;
  localparam int DELTA_W   = 39;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 5;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 72;

  localparam int SCREEN_WIDTH_DEF  = 1600;
  localparam int SCREEN_HEIGHT_DEF = 1200;
  localparam int MAP_DIM_DEF       = 32;
  localparam int FRAC_BITS_DEF     = 16;

  localparam logic [POS_W-1:0] POS_X_RST   = 21'd1441792;
  localparam logic [POS_W-1:0] POS_Y_RST   = 21'd786432;
  localparam logic [DIR_W-1:0] DIR_X_RST   = 18'h30000;
  localparam logic [DIR_W-1:0] DIR_Y_RST   = 18'h00000;
  localparam logic [DIR_W-1:0] PLANE_X_RST = 18'h00000;
  localparam logic [DIR_W-1:0] PLANE_Y_RST = 18'd43254;

  localparam logic [DELTA_W-1:0] DELTA_CAP = 39'h40_0000_0000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [CODE_W-1:0] CODE_RED    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GREEN  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_BLUE   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_YELLOW = 3'd4;
  localparam logic [CODE_W-1:0] CODE_EMPTY  = 3'd0;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;

  typedef enum logic [2:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [CODE_W-1:0] cell_value;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_x;
    logic [COL_W-1:0]  column;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         pad;
    logic               hit;
    logic [CODE_W-1:0]  wall_code;
    logic               y_side;
    logic [COLOR_W-1:0] alpha;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [ROW_W-1:0]   wall_bottom;
    logic [ROW_W-1:0]   wall_top;
    logic [COL_W-1:0]   out_column;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  // Codes other than red, green, blue and yellow show as magenta; y-side faces are drawn at half level.
  function automatic rgb_t wall_rgb(input logic [CODE_W-1:0] code, input logic y_side);
    rgb_t c;
    c = '0;
    case (code)
      CODE_RED:    c.r = COLOR_FULL;
      CODE_GREEN:  c.g = COLOR_FULL;
      CODE_BLUE:   c.b = COLOR_FULL;
      CODE_YELLOW: begin
        c.r = COLOR_FULL;
        c.g = COLOR_FULL;
      end
      default: begin
        c.r = COLOR_FULL;
        c.b = COLOR_FULL;
      end
    endcase
    if (y_side) begin
      c.r = c.r >> 1;
      c.g = c.g >> 1;
      c.b = c.b >> 1;
    end
    return c;
  endfunction

endpackage

### hw/rtl/grid_dda_column_raycaster.sv
// Grid DDA raycaster (top level; uses gdda_pkg, gdda_div and the defines header). A request with
// tuser 0 writes one wall code into the 32x32 map; a request with tuser 1 casts one screen column
// and returns one result. After reset the map is swept to empty before the first request is
// taken. The camera value comes from a reciprocal multiplication. A cast then runs through one
// shared bit-serial divider (up to four divisions), a shift-add pass per axis for the starting
// side distances, and a grid walk with a step state and a check state per cell because of the
// registered map memory read.
// The input side stays stalled until the result has been handed to the output register.
`include "grid_dda_column_raycaster_defines.svh"

module grid_dda_column_raycaster #(
  parameter int SCREEN_WIDTH  = gdda_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gdda_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAP_DIM       = gdda_pkg::MAP_DIM_DEF,
  parameter int FRAC_BITS     = gdda_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // column [10:0], cell_x [15:11], cell_y [20:16], cell_value [23:21]
  input  logic [gdda_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd [0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_column [10:0], wall_top [21:11], wall_bottom [32:22], red [40:33], green [48:41],
  // blue [56:49], alpha [64:57], y_side [65], wall_code [68:66], hit [69], zero [71:70]
  output logic [gdda_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gdda_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [gdda_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [gdda_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int POS_W   = gdda_pkg::POS_W;
  localparam int DIR_W   = gdda_pkg::DIR_W;
  localparam int DELTA_W = gdda_pkg::DELTA_W;
  localparam int CODE_W  = gdda_pkg::CODE_W;
  localparam int ROW_W   = gdda_pkg::ROW_W;
  localparam int COL_W   = gdda_pkg::COL_W;

  localparam int FX_W    = FRAC_BITS + 1;
  localparam int BIT_W   = $clog2(FX_W);
  localparam int CAM_W   = FRAC_BITS + 10;
  localparam int PROD_W  = DIR_W + CAM_W;
  localparam int RAY_W   = PROD_W - FRAC_BITS + 1;
  localparam int DIV_W   = 2 * FRAC_BITS + 24;
  localparam int ACC_W   = DELTA_W + FX_W;
  localparam int STEPS   = 2 * MAP_DIM;
  localparam int STEP_W  = $clog2(STEPS + 1);
  localparam int SD_W    = DELTA_W + 2 + STEP_W;
  localparam int INT_W   = (POS_W > FRAC_BITS) ? POS_W - FRAC_BITS : 1;
  localparam int MAPB_W  = $clog2(MAP_DIM) + 1;
  localparam int MX_W    = ((INT_W > MAPB_W) ? INT_W : MAPB_W) + 2;
  localparam int NUM_W   = ((POS_W > MX_W + FRAC_BITS) ? POS_W : MX_W + FRAC_BITS) + 2;
  localparam int DEPTH   = MAP_DIM * MAP_DIM;
  localparam int MAP_AW  = $clog2(DEPTH);
  localparam int LH_W    = $clog2(2 * SCREEN_HEIGHT + 1);

  // The camera quotient (column << (FRAC_BITS+1)) / SCREEN_WIDTH is exact with this
  // reciprocal because the scaled numerator times the width stays below 2^(CAM_SH+FRAC_BITS+1).
  localparam int CAM_SH  = COL_W + $clog2(SCREEN_WIDTH);
  localparam int RCP_W   = COL_W + FRAC_BITS + 2;
  localparam int CAMP_W  = COL_W + RCP_W;
  localparam logic [63:0] CAM_RCP_L =
    ((64'd1 << (CAM_SH + FRAC_BITS + 1)) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);
  localparam logic [RCP_W-1:0] CAM_RCP = CAM_RCP_L[RCP_W-1:0];

  localparam logic signed [CAM_W-1:0] CAM_ONE = CAM_W'(1) << FRAC_BITS;
  localparam logic signed [NUM_W-1:0] NUM_ONE = NUM_W'(1) << FRAC_BITS;
  localparam logic [FX_W-1:0]         FX_ONE  = FX_W'(1) << FRAC_BITS;
  localparam logic signed [MX_W-1:0]  MAP_LIM = MX_W'(MAP_DIM);
  localparam logic [LH_W-1:0]         LH_MAX  = LH_W'(2 * SCREEN_HEIGHT);
  localparam logic [LH_W-1:0]         HALF_H  = LH_W'(SCREEN_HEIGHT / 2);
  localparam logic [LH_W-1:0]         LAST_ROW = LH_W'(SCREEN_HEIGHT - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_RAYX, S_RAYY, S_DX, S_DX_W, S_DY, S_DY_W,
    S_SDX, S_SDY, S_STEP, S_CHECK, S_DIST, S_DIST_W, S_LH, S_LH_W, S_DONE
  } state_t;

  // Configuration registers.
  logic [POS_W-1:0] pos_x_r, pos_y_r;
  logic [DIR_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic             cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= gdda_pkg::POS_X_RST;
      pos_y_r   <= gdda_pkg::POS_Y_RST;
      dir_x_r   <= gdda_pkg::DIR_X_RST;
      dir_y_r   <= gdda_pkg::DIR_Y_RST;
      plane_x_r <= gdda_pkg::PLANE_X_RST;
      plane_y_r <= gdda_pkg::PLANE_Y_RST;
    end else if (cfg_we) begin
      case (gdda_pkg::reg_idx_t'(cfg_paddr[gdda_pkg::CFG_AW-1:2]))
        gdda_pkg::REG_POS_X:   pos_x_r   <= cfg_pwdata[POS_W-1:0];
        gdda_pkg::REG_POS_Y:   pos_y_r   <= cfg_pwdata[POS_W-1:0];
        gdda_pkg::REG_DIR_X:   dir_x_r   <= cfg_pwdata[DIR_W-1:0];
        gdda_pkg::REG_DIR_Y:   dir_y_r   <= cfg_pwdata[DIR_W-1:0];
        gdda_pkg::REG_PLANE_X: plane_x_r <= cfg_pwdata[DIR_W-1:0];
        gdda_pkg::REG_PLANE_Y: plane_y_r <= cfg_pwdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (gdda_pkg::reg_idx_t'(cfg_paddr[gdda_pkg::CFG_AW-1:2]))
      gdda_pkg::REG_POS_X:   cfg_prdata = gdda_pkg::CFG_DW'(pos_x_r);
      gdda_pkg::REG_POS_Y:   cfg_prdata = gdda_pkg::CFG_DW'(pos_y_r);
      gdda_pkg::REG_DIR_X:   cfg_prdata = gdda_pkg::CFG_DW'(dir_x_r);
      gdda_pkg::REG_DIR_Y:   cfg_prdata = gdda_pkg::CFG_DW'(dir_y_r);
      gdda_pkg::REG_PLANE_X: cfg_prdata = gdda_pkg::CFG_DW'(plane_x_r);
      gdda_pkg::REG_PLANE_Y: cfg_prdata = gdda_pkg::CFG_DW'(plane_y_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // Sequencer and datapath registers.
  state_t                    state_r;
  logic [MAP_AW-1:0]         clr_r;
  logic [COL_W-1:0]          col_r;
  logic signed [CAM_W-1:0]   cam_r;
  logic signed [RAY_W-1:0]   rdx_r, rdy_r;
  logic [DELTA_W-1:0]        dx_r, dy_r;
  logic [ACC_W-1:0]          acc_r;
  logic [BIT_W-1:0]          bit_r;
  logic [SD_W-1:0]           sdx_r, sdy_r;
  logic signed [MX_W-1:0]    mx_r, my_r;
  logic [STEP_W-1:0]         step_r;
  logic                      oob_r;
  logic                      side_r;
  logic                      hit_r;
  logic [CODE_W-1:0]         code_r;
  logic [DIV_W-1:0]          dist_r;
  logic [ROW_W-1:0]          top_r, bot_r;
  logic [CODE_W-1:0]         map_rd_r;
  logic                      out_valid_r;
  gdda_pkg::out_item_t       out_item_r;

  logic [CODE_W-1:0] map_mem [DEPTH];

  gdda_pkg::in_item_t  in_item;
  gdda_pkg::div_stat_t div_stat;
  logic                in_acc;
  logic                div_start;
  logic [DIV_W-1:0]    div_num, div_den, div_quo;
  logic [CAMP_W-1:0]   cam_prod;
  logic [CAM_W-1:0]    cam_quo;
  logic [RAY_W-1:0]    abs_x, abs_y;
  logic signed [DIR_W-1:0]  mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [RAY_W-1:0]  ray_new;
  logic [FX_W-1:0]     fx_op;
  logic [ACC_W-1:0]    acc_nxt;
  logic                step_x;
  logic signed [MX_W-1:0] mx_n, my_n;
  logic                oob_n;
  logic [MAP_AW-1:0]   idx_mx, idx_my, rd_idx;
  logic [MAP_AW-1:0]   wr_idx;
  logic                mem_we;
  logic [MAP_AW-1:0]   mem_waddr;
  logic [CODE_W-1:0]   mem_wdata;
  logic signed [NUM_W-1:0] border, num_s;
  logic [NUM_W-1:0]    num_mag;
  logic [RAY_W-1:0]    hit_den;
  logic [DIV_W-1:0]    cap_q;
  logic [LH_W-1:0]     lh_sat, half, top_v, bot_v;
  gdda_pkg::rgb_t      rgb;
  gdda_pkg::out_item_t out_nxt;

  assign in_item   = gdda_pkg::in_item_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cam_prod = CAMP_W'(col_r) * CAMP_W'(CAM_RCP);
    cam_quo  = CAM_W'(cam_prod >> CAM_SH);

    abs_x = rdx_r[RAY_W-1] ? RAY_W'(-rdx_r) : RAY_W'(rdx_r);
    abs_y = rdy_r[RAY_W-1] ? RAY_W'(-rdy_r) : RAY_W'(rdy_r);

    // One signed multiplier forms both ray components on consecutive cycles.
    mul_a   = (state_r == S_RAYX) ? $signed(plane_x_r) : $signed(plane_y_r);
    prod    = PROD_W'(mul_a) * PROD_W'(cam_r);
    ray_new = RAY_W'((state_r == S_RAYX) ? $signed(dir_x_r) : $signed(dir_y_r))
            + RAY_W'(prod >>> FRAC_BITS);

    // Fraction to the first border, then MSB-first shift-add against the delta.
    if (state_r == S_SDX) begin
      fx_op   = rdx_r[RAY_W-1] ? {1'b0, pos_x_r[FRAC_BITS-1:0]}
                               : FX_ONE - {1'b0, pos_x_r[FRAC_BITS-1:0]};
      acc_nxt = (acc_r << 1) + (fx_op[bit_r] ? ACC_W'(dx_r) : '0);
    end else begin
      fx_op   = rdy_r[RAY_W-1] ? {1'b0, pos_y_r[FRAC_BITS-1:0]}
                               : FX_ONE - {1'b0, pos_y_r[FRAC_BITS-1:0]};
      acc_nxt = (acc_r << 1) + (fx_op[bit_r] ? ACC_W'(dy_r) : '0);
    end

    // Ties go to the y axis.
    step_x = sdx_r < sdy_r;
    mx_n   = mx_r;
    my_n   = my_r;
    if (step_x) begin
      mx_n = rdx_r[RAY_W-1] ? mx_r - MX_W'(1) : mx_r + MX_W'(1);
    end else begin
      my_n = rdy_r[RAY_W-1] ? my_r - MX_W'(1) : my_r + MX_W'(1);
    end
    oob_n  = (mx_n < 0) || (mx_n >= MAP_LIM) || (my_n < 0) || (my_n >= MAP_LIM);
    idx_mx = MAP_AW'(mx_n);
    idx_my = MAP_AW'(my_n);
    rd_idx = oob_n ? '0 : idx_mx * MAP_AW'(MAP_DIM) + idx_my;

    wr_idx = MAP_AW'(in_item.cell_x) * MAP_AW'(MAP_DIM) + MAP_AW'(in_item.cell_y);
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = gdda_pkg::CODE_EMPTY;
    end else begin
      mem_we    = in_acc && (in_tuser == gdda_pkg::CMD_WRITE)
               && (int'(in_item.cell_x) < MAP_DIM) && (int'(in_item.cell_y) < MAP_DIM);
      mem_waddr = wr_idx;
      mem_wdata = in_item.cell_value;
    end

    // Perpendicular distance numerator on the axis of the last step.
    if (side_r) begin
      border  = (NUM_W'(my_r) <<< FRAC_BITS) + (rdy_r[RAY_W-1] ? NUM_ONE : '0);
      num_s   = border - NUM_W'(pos_y_r);
      hit_den = abs_y;
    end else begin
      border  = (NUM_W'(mx_r) <<< FRAC_BITS) + (rdx_r[RAY_W-1] ? NUM_ONE : '0);
      num_s   = border - NUM_W'(pos_x_r);
      hit_den = abs_x;
    end
    num_mag = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);

    cap_q = (div_quo > DIV_W'(gdda_pkg::DELTA_CAP)) ? DIV_W'(gdda_pkg::DELTA_CAP) : div_quo;

    lh_sat = (div_quo > DIV_W'(LH_MAX)) ? LH_MAX : div_quo[LH_W-1:0];
    half   = lh_sat >> 1;
    top_v  = (half > HALF_H) ? '0 : HALF_H - half;
    bot_v  = half + HALF_H;
    if (bot_v > LAST_ROW) begin
      bot_v = LAST_ROW;
    end

    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_DX: begin
        div_start = (abs_x != '0);
        div_num   = DIV_W'(1) << (2 * FRAC_BITS);
        div_den   = DIV_W'(abs_x);
      end
      S_DY: begin
        div_start = (abs_y != '0);
        div_num   = DIV_W'(1) << (2 * FRAC_BITS);
        div_den   = DIV_W'(abs_y);
      end
      S_DIST: begin
        div_start = (hit_den != '0);
        div_num   = DIV_W'(num_mag) << FRAC_BITS;
        div_den   = DIV_W'(hit_den);
      end
      S_LH: begin
        div_start = 1'b1;
        div_num   = DIV_W'(SCREEN_HEIGHT) << FRAC_BITS;
        div_den   = dist_r;
      end
      default: ;
    endcase

    rgb                 = gdda_pkg::wall_rgb(code_r, side_r);
    out_nxt             = '0;
    out_nxt.out_column  = col_r;
    out_nxt.alpha       = gdda_pkg::COLOR_FULL;
    out_nxt.hit         = hit_r;
    if (hit_r) begin
      out_nxt.wall_top    = top_r;
      out_nxt.wall_bottom = bot_r;
      out_nxt.red         = rgb.r;
      out_nxt.green       = rgb.g;
      out_nxt.blue        = rgb.b;
      out_nxt.y_side      = side_r;
      out_nxt.wall_code   = code_r;
    end
  end

  gdda_div #(
    .W (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    map_rd_r <= map_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + MAP_AW'(1);
          if (clr_r == MAP_AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (in_tuser == gdda_pkg::CMD_CAST)) begin
            col_r   <= in_item.column;
            hit_r   <= 1'b0;
            side_r  <= 1'b0;
            code_r  <= gdda_pkg::CODE_EMPTY;
            top_r   <= '0;
            bot_r   <= '0;
            mx_r    <= MX_W'(pos_x_r >> FRAC_BITS);
            my_r    <= MX_W'(pos_y_r >> FRAC_BITS);
            state_r <= S_CAM;
          end
        end
        S_CAM: begin
          cam_r   <= $signed(cam_quo) - CAM_ONE;
          state_r <= S_RAYX;
        end
        S_RAYX: begin
          rdx_r   <= ray_new;
          state_r <= S_RAYY;
        end
        S_RAYY: begin
          rdy_r   <= ray_new;
          state_r <= S_DX;
        end
        S_DX: begin
          if (abs_x == '0) begin
            dx_r    <= gdda_pkg::DELTA_CAP;
            state_r <= S_DY;
          end else begin
            state_r <= S_DX_W;
          end
        end
        S_DX_W: begin
          if (div_stat.done) begin
            dx_r    <= cap_q[DELTA_W-1:0];
            state_r <= S_DY;
          end
        end
        S_DY: begin
          acc_r <= '0;
          bit_r <= BIT_W'(FRAC_BITS);
          if (abs_y == '0) begin
            dy_r    <= gdda_pkg::DELTA_CAP;
            state_r <= S_SDX;
          end else begin
            state_r <= S_DY_W;
          end
        end
        S_DY_W: begin
          if (div_stat.done) begin
            dy_r    <= cap_q[DELTA_W-1:0];
            state_r <= S_SDX;
          end
        end
        S_SDX: begin
          acc_r <= acc_nxt;
          bit_r <= bit_r - BIT_W'(1);
          if (bit_r == '0) begin
            sdx_r   <= SD_W'(acc_nxt >> FRAC_BITS);
            acc_r   <= '0;
            bit_r   <= BIT_W'(FRAC_BITS);
            state_r <= S_SDY;
          end
        end
        S_SDY: begin
          acc_r <= acc_nxt;
          bit_r <= bit_r - BIT_W'(1);
          if (bit_r == '0) begin
            sdy_r   <= SD_W'(acc_nxt >> FRAC_BITS);
            step_r  <= '0;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_x) begin
            sdx_r <= sdx_r + SD_W'(dx_r);
          end else begin
            sdy_r <= sdy_r + SD_W'(dy_r);
          end
          mx_r    <= mx_n;
          my_r    <= my_n;
          side_r  <= !step_x;
          oob_r   <= oob_n;
          step_r  <= step_r + STEP_W'(1);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          // The map word for the new cell arrives in map_rd_r this cycle.
          if (oob_r) begin
            state_r <= S_DONE;
          end else if (map_rd_r != gdda_pkg::CODE_EMPTY) begin
            hit_r   <= 1'b1;
            code_r  <= map_rd_r;
            state_r <= S_DIST;
          end else if (step_r == STEP_W'(STEPS)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_DIST: begin
          if (hit_den == '0) begin
            hit_r   <= 1'b0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIST_W;
          end
        end
        S_DIST_W: begin
          if (div_stat.done) begin
            dist_r <= div_quo;
            if (div_quo == '0) begin
              hit_r   <= 1'b0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_LH;
            end
          end
        end
        S_LH: state_r <= S_LH_W;
        S_LH_W: begin
          if (div_stat.done) begin
            top_r   <= ROW_W'(top_v);
            bot_r   <= ROW_W'(bot_v);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_item_r  <= out_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  `GDDA_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> state_r == S_CLEAR)
  `GDDA_ASSERT(a_div_idle_on_start, div_start |-> !div_stat.busy)
  `GDDA_ASSERT(a_step_limit, state_r == S_STEP |-> step_r < STEP_W'(STEPS))
  `GDDA_ASSERT(a_miss_is_blank, out_valid_r && !out_item_r.hit |->
      out_item_r.wall_top == '0 && out_item_r.wall_code == gdda_pkg::CODE_EMPTY &&
      out_item_r.red == '0 && !out_item_r.y_side)

endmodule

### hw/rtl/gdda_div.sv
// Restoring unsigned divider, one quotient bit per cycle, shared by all divisions.
// Depends on gdda_pkg for the status struct.
module gdda_div #(
  parameter int W = 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  output gdda_pkg::div_stat_t stat,
  output logic [W-1:0]        quo
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W:0]   shifted;
  logic         ge;
  logic [W:0]   diff;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

### test/tb_grid_dda_column_raycaster.sv
// Testbench for the grid DDA column raycaster: map writes, column casts and camera settings.
// Predicts each cast result with its own fixed-point walk; depends on gdda_pkg and the top level.
module tb_grid_dda_column_raycaster;

  localparam int MAPN = 32;
  localparam int SCR_W = 1600;
  localparam int SCR_H = 1200;
  localparam int FB = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [63:0] CAP = 64'd1 << 38;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [gdda_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [gdda_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [gdda_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [gdda_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [gdda_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  grid_dda_column_raycaster DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Camera and map copy used for prediction.
  logic [gdda_pkg::POS_W-1:0] cam_px, cam_py;
  logic [gdda_pkg::DIR_W-1:0] cam_dx, cam_dy, cam_plx, cam_ply;
  logic [gdda_pkg::CODE_W-1:0] wall_map [MAPN*MAPN];

  gdda_pkg::out_item_t column_q[$];
  int errors = 0;
  int idle_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint fl_shift(input longint v);
    if (v >= 0) return v >>> FB;
    return -(((-v) - 1) >>> FB) - 1;
  endfunction

  function automatic longint absval(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint delta_for(input longint ray);
    longint a, d;
    a = absval(ray);
    if (a == 0) return CAP;
    d = (64'd1 << (2*FB)) / a;
    return d > CAP ? CAP : d;
  endfunction

  function automatic gdda_pkg::out_item_t cast_column(input logic [gdda_pkg::COL_W-1:0] col);
    gdda_pkg::out_item_t r;
    longint px, py, cam, rx, ry, ddx, ddy, sdx, sdy, fx, fy, num, dv, wall_dist, lh, top, bot;
    longint mx, my, sx, sy;
    int side, hit;
    logic [gdda_pkg::CODE_W-1:0] code;
    gdda_pkg::rgb_t c;
    side = 0; hit = 0; code = gdda_pkg::CODE_EMPTY;
    px = cam_px; py = cam_py;
    cam = ((2 * longint'(col)) << FB) / SCR_W - (64'd1 << FB);
    rx = longint'($signed(cam_dx)) + fl_shift(longint'($signed(cam_plx)) * cam);
    ry = longint'($signed(cam_dy)) + fl_shift(longint'($signed(cam_ply)) * cam);
    mx = px >>> FB; my = py >>> FB;
    fx = px & 16'hFFFF; fy = py & 16'hFFFF;
    ddx = delta_for(rx); ddy = delta_for(ry);
    if (rx < 0) begin sx = -1; sdx = (fx * ddx) >>> FB; end
    else begin sx = 1; sdx = (((64'd1 << FB) - fx) * ddx) >>> FB; end
    if (ry < 0) begin sy = -1; sdy = (fy * ddy) >>> FB; end
    else begin sy = 1; sdy = (((64'd1 << FB) - fy) * ddy) >>> FB; end
    for (int i = 0; i < 2*MAPN; i++) begin
      if (sdx < sdy) begin sdx += ddx; mx += sx; side = 0; end
      else begin sdy += ddy; my += sy; side = 1; end
      if (mx < 0 || mx >= MAPN || my < 0 || my >= MAPN) break;
      code = wall_map[mx*MAPN + my];
      if (code != gdda_pkg::CODE_EMPTY) begin hit = 1; break; end
    end
    r = '0;
    r.out_column = col;
    r.alpha = gdda_pkg::COLOR_FULL;
    if (hit) begin
      if (side == 0) begin
        num = (mx << FB) + (sx < 0 ? (64'd1 << FB) : 0) - px; dv = absval(rx);
      end else begin
        num = (my << FB) + (sy < 0 ? (64'd1 << FB) : 0) - py; dv = absval(ry);
      end
      wall_dist = dv == 0 ? 0 : (absval(num) << FB) / dv;
      if (wall_dist == 0) hit = 0;
      else begin
        lh = (longint'(SCR_H) << FB) / wall_dist;
        if (lh > 2*SCR_H) lh = 2*SCR_H;
        top = SCR_H/2 - lh/2;
        if (top < 0) top = 0;
        bot = lh/2 + SCR_H/2;
        if (bot >= SCR_H) bot = SCR_H - 1;
        c = '0;
        case (code)
          gdda_pkg::CODE_RED: c.r = gdda_pkg::COLOR_FULL;
          gdda_pkg::CODE_GREEN: c.g = gdda_pkg::COLOR_FULL;
          gdda_pkg::CODE_BLUE: c.b = gdda_pkg::COLOR_FULL;
          gdda_pkg::CODE_YELLOW: begin
            c.r = gdda_pkg::COLOR_FULL; c.g = gdda_pkg::COLOR_FULL;
          end
          default: begin c.r = gdda_pkg::COLOR_FULL; c.b = gdda_pkg::COLOR_FULL; end
        endcase
        if (side == 1) begin c.r >>= 1; c.g >>= 1; c.b >>= 1; end
        r.wall_top = gdda_pkg::ROW_W'(top); r.wall_bottom = gdda_pkg::ROW_W'(bot);
        r.red = c.r; r.green = c.g; r.blue = c.b;
        r.y_side = side[0]; r.wall_code = code; r.hit = 1'b1;
      end
    end
    return r;
  endfunction

  // Sends one request and, once accepted, updates the predicted state.
  task automatic send_request(input logic cmd, input logic [gdda_pkg::COL_W-1:0] col,
                              input logic [gdda_pkg::CELL_W-1:0] cx,
                              input logic [gdda_pkg::CELL_W-1:0] cy,
                              input logic [gdda_pkg::CODE_W-1:0] val);
    gdda_pkg::in_item_t it;
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    it.column = col; it.cell_x = cx; it.cell_y = cy; it.cell_value = val;
    in_tdata <= it;
    in_tuser <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (cmd == gdda_pkg::CMD_WRITE) wall_map[cx*MAPN + cy] = val;
    else column_q.push_back(cast_column(col));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (column_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input gdda_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= gdda_pkg::CFG_AW'(4*idx); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      gdda_pkg::REG_POS_X: cam_px = gdda_pkg::POS_W'(val);
      gdda_pkg::REG_POS_Y: cam_py = gdda_pkg::POS_W'(val);
      gdda_pkg::REG_DIR_X: cam_dx = gdda_pkg::DIR_W'(val);
      gdda_pkg::REG_DIR_Y: cam_dy = gdda_pkg::DIR_W'(val);
      gdda_pkg::REG_PLANE_X: cam_plx = gdda_pkg::DIR_W'(val);
      default: cam_ply = gdda_pkg::DIR_W'(val);
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_camera(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] dx, input logic [31:0] dy,
                            input logic [31:0] plx, input logic [31:0] ply);
    drain();
    write_reg(gdda_pkg::REG_POS_X, px); write_reg(gdda_pkg::REG_POS_Y, py);
    write_reg(gdda_pkg::REG_DIR_X, dx); write_reg(gdda_pkg::REG_DIR_Y, dy);
    write_reg(gdda_pkg::REG_PLANE_X, plx); write_reg(gdda_pkg::REG_PLANE_Y, ply);
  endtask

  task automatic cast(input logic [gdda_pkg::COL_W-1:0] col);
    send_request(gdda_pkg::CMD_CAST, col, gdda_pkg::CELL_W'($urandom),
                 gdda_pkg::CELL_W'($urandom), gdda_pkg::CODE_W'($urandom));
  endtask

  task automatic put_cell(input int x, input int y, input int v);
    send_request(gdda_pkg::CMD_WRITE, gdda_pkg::COL_W'($urandom), gdda_pkg::CELL_W'(x),
                 gdda_pkg::CELL_W'(y), gdda_pkg::CODE_W'(v));
  endtask

  // Border walls with all codes, then the directed corner cases.
  task automatic test_directed();
    cast(11'd800);
    for (int i = 0; i < 8; i++) put_cell(0, 4*i, i);
    put_cell(31, 31, 7);
    cast(11'd0); cast(11'd1599); cast(11'd2047); cast(11'd800);
    put_cell(21, 12, 5);
    cast(11'd800);
    put_cell(21, 12, 0);
    // Camera at the largest position, in the last map cell; then an axis-aligned ray with zero y component.
    set_camera(32'h1FFFFF, 32'h1FFFFF, 32'h1FFFF, 32'h20000, 32'h20000, 32'h1FFFF);
    cast(11'd0); cast(11'd800); cast(11'd1599);
    set_camera(32'h18000, 32'h18000, 32'h10000, 0, 0, 0);
    cast(11'd800); cast(11'd400);
    set_camera(0, 0, 32'h10000, 32'h10000, 0, 0);
    cast(11'd0); cast(11'd1024);
  endtask

  task automatic test_random_scenes();
    for (int s = 0; s < 14; s++) begin
      set_camera($urandom_range(s < 2 ? 0 : 32'h10000, s == 0 ? 32'h1FFFFF : 32'h1EFFFF),
                 $urandom_range(32'h10000, 32'h1EFFFF), $urandom_range(0, 32'h3FFFF),
                 $urandom_range(0, 32'h3FFFF), $urandom_range(0, 32'h3FFFF),
                 $urandom_range(0, 32'h3FFFF));
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(0, 2) == 0)
          put_cell($urandom_range(0, 31), $urandom_range(0, 31),
                   ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7));
        else
          cast(gdda_pkg::COL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                            : $urandom_range(0, 1599)));
      end
    end
  endtask

  // The result side waits a drawn number of cycles before taking each result.
  initial begin
    int rx_wait;
    @(negedge clk);
    forever begin
      rx_wait = $urandom_range(0, 6);
      if (rx_wait != 0) begin
        out_tready <= 1'b0;
        repeat (rx_wait) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    gdda_pkg::out_item_t g, w;
    if (rst_n && out_tvalid && out_tready) begin
      g = out_tdata;
      if (column_q.size() == 0) report("unexpected result column", g.out_column, -1);
      else begin
        w = column_q.pop_front();
        if (g.out_column != w.out_column) report("out_column", g.out_column, w.out_column);
        if (g.wall_top != w.wall_top) report("wall_top", g.wall_top, w.wall_top);
        if (g.wall_bottom != w.wall_bottom) report("wall_bottom", g.wall_bottom, w.wall_bottom);
        if (g.red != w.red) report("red", g.red, w.red);
        if (g.green != w.green) report("green", g.green, w.green);
        if (g.blue != w.blue) report("blue", g.blue, w.blue);
        if (g.alpha != w.alpha) report("alpha", g.alpha, w.alpha);
        if (g.y_side != w.y_side) report("y_side", g.y_side, w.y_side);
        if (g.wall_code != w.wall_code) report("wall_code", g.wall_code, w.wall_code);
        if (g.hit != w.hit) report("hit", g.hit, w.hit);
      end
    end
  end

  // Allows for the map clearing sweep after reset and the slowest cast.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cam_px = gdda_pkg::POS_X_RST; cam_py = gdda_pkg::POS_Y_RST;
    cam_dx = gdda_pkg::DIR_X_RST; cam_dy = gdda_pkg::DIR_Y_RST;
    cam_plx = gdda_pkg::PLANE_X_RST; cam_ply = gdda_pkg::PLANE_Y_RST;
    foreach (wall_map[i]) wall_map[i] = gdda_pkg::CODE_EMPTY;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_scenes();
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/gdda_pkg.sv
hw/rtl/gdda_div.sv
hw/rtl/grid_dda_column_raycaster.sv
test/tb_grid_dda_column_raycaster.sv
